// ===== sv/smr_pkg.sv =====
// Shared widths, codes, tables and controller/datapath bundles for the moment reducer.
package smr_pkg;

  // Field widths and fixed-point format
  localparam int D_W        = 24;
  localparam int V_W        = 24;
  localparam int DEN_W      = 32;
  localparam int DISP_W     = 48;
  localparam int DIAG_W     = 47;
  localparam int CNT_W      = 8;
  localparam int FRAC       = 12;

  // Internal accumulator and arithmetic widths
  localparam int WS_W       = 32;
  localparam int WV_W       = 36;
  localparam int FM_W       = 46;
  localparam int SM_W       = 56;
  localparam int MA_W       = 37;
  localparam int MB_W       = 25;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int PSH_W      = PROD_W - FRAC;
  localparam int DVD_W      = SM_W + FRAC;
  localparam int DVS_W      = WS_W;
  localparam int S_W        = DVD_W + 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_GEO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PER_STREAM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RHO    = 2'd2;
  localparam logic [D_W-1:0] INV_RHO_RST = 24'd4096;

  localparam int MAX_STREAMS_DEF = 255;

  // Shared multiplier operations
  typedef enum logic [2:0] {
    OP_WV   = 3'd0,
    OP_SM   = 3'd1,
    OP_MM   = 3'd2,
    OP_DREC = 3'd3,
    OP_DSUM = 3'd4
  } smr_op_t;

  // Second-moment pair table, order xx xy xz yy yz zz
  function automatic logic [1:0] pair_a(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0, 3'd1, 3'd2: r = 2'd0;
      3'd3, 3'd4:       r = 2'd1;
      3'd5:             r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pair_b(input logic [2:0] j);
    logic [1:0] r;
    unique case (j)
      3'd0:             r = 2'd0;
      3'd1, 3'd3:       r = 2'd1;
      3'd2, 3'd4, 3'd5: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic    cap;
    logic    mul_en;
    smr_op_t mul_op;
    logic [2:0] mul_idx;
    logic    acc_rec;
    logic    div_start;
    logic [3:0] div_idx;
    logic    mean_wr;
    logic    disp_wr;
    logic    res_clr;
    logic    clr_point;
    logic    load_echo;
    logic    load_sum;
  } smr_cmd_t;

  typedef struct packed {
    logic rec;
    logic last;
    logic acc_ok;
    logic per_stream;
    logic w_zero;
    logic cnt_ge2;
    logic div_busy;
    logic div_done;
    logic out_free;
  } smr_sts_t;

endpackage

// ===== sv/smr_if.sv =====
// Input record and result channel interfaces.
interface smr_in_if;
  import smr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [D_W-1:0]        density_geometric;
  logic [D_W-1:0]        density_interpolated;
  logic signed [V_W-1:0] vel_x;
  logic signed [V_W-1:0] vel_y;
  logic signed [V_W-1:0] vel_z;
  logic                  no_stream;
  logic                  last;

  modport source (output valid, density_geometric, density_interpolated, vel_x, vel_y, vel_z,
                  no_stream, last, input ready);
  modport sink   (input valid, density_geometric, density_interpolated, vel_x, vel_y, vel_z,
                  no_stream, last, output ready);
endinterface

interface smr_out_if;
  import smr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [DEN_W-1:0]         density;
  logic signed [V_W-1:0]    mean_vx;
  logic signed [V_W-1:0]    mean_vy;
  logic signed [V_W-1:0]    mean_vz;
  logic [DIAG_W-1:0]        disp_xx;
  logic signed [DISP_W-1:0] disp_xy;
  logic signed [DISP_W-1:0] disp_xz;
  logic [DIAG_W-1:0]        disp_yy;
  logic signed [DISP_W-1:0] disp_yz;
  logic [DIAG_W-1:0]        disp_zz;
  logic [CNT_W-1:0]         stream_count;

  modport source (output valid, kind, density, mean_vx, mean_vy, mean_vz, disp_xx, disp_xy,
                  disp_xz, disp_yy, disp_yz, disp_zz, stream_count, input ready);
  modport sink   (input valid, kind, density, mean_vx, mean_vy, mean_vz, disp_xx, disp_xy,
                  disp_xz, disp_yy, disp_yz, disp_zz, stream_count, output ready);
endinterface

// ===== sv/smr_div.sv =====
// Serial restoring divider, one quotient bit per cycle, signed dividend over unsigned divisor.
module smr_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         neg,
  input  logic [smr_pkg::DVD_W-1:0]    mag,
  input  logic [smr_pkg::DVS_W-1:0]    dvs,
  output logic                         busy,
  output logic                         done,
  output logic signed [smr_pkg::DVD_W:0] quo
);
  import smr_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] q_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One trial subtraction per cycle
  always_comb begin
    rem_sh = {rem_r, q_r[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge     = !diff[DVS_W+1];
  end

  // Control: count iterations, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Datapath: shift dividend in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= neg;
      dvs_r <= dvs;
      rem_r <= '0;
      q_r   <= mag;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      q_r   <= {q_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ===== sv/smr_dp.sv =====
// Datapath: configuration, record capture, shared multiplier, moments, divider, result register.
module smr_dp #(
  parameter int MAX_STREAMS = smr_pkg::MAX_STREAMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  smr_in_if.sink                         in_ch,
  smr_out_if.source                      out_ch,
  input  smr_pkg::smr_cmd_t              cmd,
  output smr_pkg::smr_sts_t              sts
);
  import smr_pkg::*;

  // Configuration registers
  logic           use_geo_r;
  logic           per_stream_r;
  logic [D_W-1:0] inv_r;

  // Captured transaction
  logic [D_W-1:0]        w_r;
  logic signed [V_W-1:0] v_r [3];
  logic                  ns_r;
  logic                  last_r;

  // Point accumulators
  logic [WS_W-1:0]         ws_r;
  logic signed [FM_W-1:0]  fm_r [3];
  logic signed [SM_W-1:0]  sm_r [6];
  logic [CNT_W-1:0]        cnt_r;
  logic signed [WV_W-1:0]  wv_r [3];

  // Multiplier and its accumulate stage
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PSH_W-1:0]  psh;
  logic                     acc_v_r;
  smr_op_t                  acc_op_r;
  logic [2:0]               acc_idx_r;
  logic [1:0]               pa;
  logic [1:0]               pb;
  logic [1:0]               apa;
  logic [DEN_W-1:0]         den_sat;

  // Close results
  logic signed [WV_W-1:0]   mm_r;
  logic [DEN_W-1:0]         den_r;
  logic signed [V_W-1:0]    mean_r [3];
  logic signed [DISP_W-1:0] disp_r [6];

  // Divider hookup
  logic [1:0]               fm_sel;
  logic [2:0]               sm_sel;
  logic signed [DVD_W-1:0]  dvd;
  logic [DVD_W-1:0]         dmag;
  logic                     div_busy;
  logic                     div_done;
  logic signed [DVD_W:0]    quo;
  logic signed [V_W-1:0]    mean_val;
  logic signed [S_W-1:0]    s_val;
  logic signed [DISP_W-1:0] disp_val;
  logic [2:0]               dj;

  // Result register
  logic                     out_valid_r;
  logic                     kind_r;
  logic [DEN_W-1:0]         o_den_r;
  logic signed [V_W-1:0]    o_mean_r [3];
  logic signed [DISP_W-1:0] o_disp_r [6];
  logic [CNT_W-1:0]         o_cnt_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_geo_r    <= 1'b0;
      per_stream_r <= 1'b0;
      inv_r        <= INV_RHO_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_USE_GEO:    use_geo_r    <= cfg_wdata[0];
        CFG_PER_STREAM: per_stream_r <= cfg_wdata[0];
        CFG_INV_RHO:    inv_r        <= cfg_wdata[D_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction, select the weight
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      w_r    <= use_geo_r ? in_ch.density_geometric : in_ch.density_interpolated;
      v_r[0] <= in_ch.vel_x;
      v_r[1] <= in_ch.vel_y;
      v_r[2] <= in_ch.vel_z;
      ns_r   <= in_ch.no_stream;
      last_r <= in_ch.last;
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    pa = pair_a(cmd.mul_idx);
    pb = pair_b(cmd.mul_idx);
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      OP_WV: begin
        ma = {{(MA_W-D_W){1'b0}}, w_r};
        mb = {{(MB_W-V_W){v_r[cmd.mul_idx[1:0]][V_W-1]}}, v_r[cmd.mul_idx[1:0]]};
      end
      OP_SM: begin
        ma = {{(MA_W-WV_W){wv_r[pa][WV_W-1]}}, wv_r[pa]};
        mb = {{(MB_W-V_W){v_r[pb][V_W-1]}}, v_r[pb]};
      end
      OP_MM: begin
        ma = {{(MA_W-V_W){mean_r[pa][V_W-1]}}, mean_r[pa]};
        mb = {{(MB_W-V_W){mean_r[pb][V_W-1]}}, mean_r[pb]};
      end
      OP_DREC: begin
        ma = {{(MA_W-D_W){1'b0}}, w_r};
        mb = {{(MB_W-D_W){1'b0}}, inv_r};
      end
      OP_DSUM: begin
        ma = {{(MA_W-WS_W){1'b0}}, ws_r};
        mb = {{(MB_W-D_W){1'b0}}, inv_r};
      end
      default: ;
    endcase
  end

  // Multiply, and remember which accumulator takes the product
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r    <= ma * mb;
      acc_op_r  <= cmd.mul_op;
      acc_idx_r <= cmd.mul_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_v_r <= 1'b0;
    else        acc_v_r <= cmd.mul_en;
  end

  // Floor back to Q12.12 and saturate densities
  always_comb begin
    psh     = prod_r[PROD_W-1:FRAC];
    apa     = pair_a(acc_idx_r);
    den_sat = (|psh[PSH_W-1:DEN_W]) ? {DEN_W{1'b1}} : psh[DEN_W-1:0];
  end

  // Moments: accumulate products, clear on point close
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_point) begin
      ws_r  <= '0;
      cnt_r <= '0;
      for (int i = 0; i < 3; i++) fm_r[i] <= '0;
      for (int j = 0; j < 6; j++) sm_r[j] <= '0;
    end else begin
      if (cmd.acc_rec) begin
        ws_r  <= ws_r + {{(WS_W-D_W){1'b0}}, w_r};
        cnt_r <= cnt_r + 1'b1;
      end
      if (acc_v_r && acc_op_r == OP_WV) begin
        fm_r[acc_idx_r[1:0]] <= fm_r[acc_idx_r[1:0]]
                                + {{(FM_W-WV_W){psh[WV_W-1]}}, psh[WV_W-1:0]};
      end
      if (acc_v_r && acc_op_r == OP_SM) begin
        sm_r[acc_idx_r] <= sm_r[acc_idx_r] + {{(SM_W-PSH_W){psh[PSH_W-1]}}, psh};
      end
    end
  end

  // Product results that are kept, not summed
  always_ff @(posedge clk) begin
    if (acc_v_r) begin
      case (acc_op_r)
        OP_WV:            wv_r[acc_idx_r[1:0]] <= psh[WV_W-1:0];
        OP_MM:            mm_r <= psh[WV_W-1:0];
        OP_DREC, OP_DSUM: den_r <= den_sat;
        default: ;
      endcase
    end
  end

  // Dividend: moment scaled by 4096, split into sign and magnitude
  always_comb begin
    fm_sel = (cmd.div_idx < 4'd3) ? cmd.div_idx[1:0] : 2'd0;
    sm_sel = (cmd.div_idx < 4'd3) ? 3'd0 : 3'(cmd.div_idx - 4'd3);
    if (cmd.div_idx < 4'd3)
      dvd = {{(SM_W-FM_W){fm_r[fm_sel][FM_W-1]}}, fm_r[fm_sel], {FRAC{1'b0}}};
    else
      dvd = {sm_r[sm_sel], {FRAC{1'b0}}};
    dmag = dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
  end

  smr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .neg   (dvd[DVD_W-1]),
    .mag   (dmag),
    .dvs   (ws_r),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  // Saturate the mean; form and clamp the dispersion entry
  always_comb begin
    dj = sm_sel;
    if ((&quo[DVD_W:V_W-1]) || !(|quo[DVD_W:V_W-1]))
      mean_val = quo[V_W-1:0];
    else
      mean_val = quo[DVD_W] ? {1'b1, {(V_W-1){1'b0}}} : {1'b0, {(V_W-1){1'b1}}};

    s_val = {quo[DVD_W], quo} - {{(S_W-WV_W){mm_r[WV_W-1]}}, mm_r};
    if (pair_a(dj) == pair_b(dj)) begin
      if (s_val[S_W-1])
        disp_val = '0;
      else if (|s_val[S_W-1:DIAG_W])
        disp_val = {1'b0, {DIAG_W{1'b1}}};
      else
        disp_val = s_val[DISP_W-1:0];
    end else begin
      if ((&s_val[S_W-1:DISP_W-1]) || !(|s_val[S_W-1:DISP_W-1]))
        disp_val = s_val[DISP_W-1:0];
      else
        disp_val = s_val[S_W-1] ? {1'b1, {(DISP_W-1){1'b0}}} : {1'b0, {(DISP_W-1){1'b1}}};
    end
  end

  // Summary means and dispersion; zero at the start of each close
  always_ff @(posedge clk) begin
    if (cmd.res_clr) begin
      for (int i = 0; i < 3; i++) mean_r[i] <= '0;
      for (int j = 0; j < 6; j++) disp_r[j] <= '0;
    end else begin
      if (cmd.mean_wr) mean_r[fm_sel] <= mean_val;
      if (cmd.disp_wr) disp_r[dj] <= disp_val;
    end
  end

  // Result register: load when free, drop on take
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_echo || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_echo) begin
      kind_r  <= 1'b0;
      o_den_r <= den_r;
      o_cnt_r <= '0;
      for (int i = 0; i < 3; i++) o_mean_r[i] <= v_r[i];
      for (int j = 0; j < 6; j++) o_disp_r[j] <= '0;
    end else if (cmd.load_sum) begin
      kind_r  <= 1'b1;
      o_den_r <= den_r;
      o_cnt_r <= cnt_r;
      for (int i = 0; i < 3; i++) o_mean_r[i] <= mean_r[i];
      for (int j = 0; j < 6; j++) o_disp_r[j] <= disp_r[j];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = kind_r;
  assign out_ch.density      = o_den_r;
  assign out_ch.mean_vx      = o_mean_r[0];
  assign out_ch.mean_vy      = o_mean_r[1];
  assign out_ch.mean_vz      = o_mean_r[2];
  assign out_ch.disp_xx      = o_disp_r[0][DIAG_W-1:0];
  assign out_ch.disp_xy      = o_disp_r[1];
  assign out_ch.disp_xz      = o_disp_r[2];
  assign out_ch.disp_yy      = o_disp_r[3][DIAG_W-1:0];
  assign out_ch.disp_yz      = o_disp_r[4];
  assign out_ch.disp_zz      = o_disp_r[5][DIAG_W-1:0];
  assign out_ch.stream_count = o_cnt_r;

  // Status to the controller
  always_comb begin
    sts.rec        = !ns_r;
    sts.last       = last_r;
    sts.acc_ok     = cnt_r < CNT_W'(MAX_STREAMS);
    sts.per_stream = per_stream_r;
    sts.w_zero     = (ws_r == '0);
    sts.cnt_ge2    = (cnt_r >= CNT_W'(2));
    sts.div_busy   = div_busy;
    sts.div_done   = div_done;
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

endmodule

// ===== sv/smr_ctrl.sv =====
// Controller: sequences record multiplies, the close divisions and result loads.
module smr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  smr_pkg::smr_sts_t sts,
  output smr_pkg::smr_cmd_t cmd
);
  import smr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DEC   = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_WAIT  = 10'b00_0000_1000,
    S_ECHO  = 10'b00_0001_0000,
    S_CDEN  = 10'b00_0010_0000,
    S_CGAP  = 10'b00_0100_0000,
    S_CDIV  = 10'b00_1000_0000,
    S_CWAIT = 10'b01_0000_0000,
    S_CSUM  = 10'b10_0000_0000
  } smr_state_t;

  localparam logic [3:0] STEP_DEN  = 4'd9;
  localparam logic [3:0] STEP_LAST = 4'd8;

  smr_state_t state_r, state_nxt;
  logic [3:0] step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.rec) begin
          step_nxt  = sts.acc_ok ? 4'd0 : STEP_DEN;
          state_nxt = S_MUL;
        end else if (sts.last) begin
          state_nxt = S_CDEN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Weighted velocities, second moments, then the echo density; past the stream limit only the echo density
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (step_r < 4'd3) begin
          cmd.mul_op  = OP_WV;
          cmd.mul_idx = step_r[2:0];
        end else if (step_r < STEP_DEN) begin
          cmd.mul_op  = OP_SM;
          cmd.mul_idx = 3'(step_r - 4'd3);
        end else begin
          cmd.mul_op  = OP_DREC;
        end
        if (step_r == 4'd0) cmd.acc_rec = 1'b1;
        if (step_r == STEP_DEN) state_nxt = S_WAIT;
        else                    step_nxt  = step_r + 1'b1;
      end
      S_WAIT: begin
        if (sts.per_stream) state_nxt = S_ECHO;
        else if (sts.last)  state_nxt = S_CDEN;
        else                state_nxt = S_IDLE;
      end
      S_ECHO: begin
        if (sts.out_free) begin
          cmd.load_echo = 1'b1;
          state_nxt     = sts.last ? S_CDEN : S_IDLE;
        end
      end
      // Close: total density first, then the divisions unless the weight sum is zero
      S_CDEN: begin
        cmd.res_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = OP_DSUM;
        state_nxt   = S_CGAP;
      end
      S_CGAP: begin
        if (sts.w_zero) begin
          state_nxt = S_CSUM;
        end else begin
          step_nxt  = '0;
          state_nxt = S_CDIV;
        end
      end
      S_CDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_idx   = step_r;
        if (step_r >= 4'd3) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_op  = OP_MM;
          cmd.mul_idx = 3'(step_r - 4'd3);
        end
        state_nxt = S_CWAIT;
      end
      S_CWAIT: begin
        cmd.div_idx = step_r;
        if (sts.div_done) begin
          if (step_r < 4'd3) cmd.mean_wr = 1'b1;
          else               cmd.disp_wr = 1'b1;
          step_nxt = step_r + 1'b1;
          if ((step_r == 4'd2 && !sts.cnt_ge2) || step_r == STEP_LAST)
            state_nxt = S_CSUM;
          else
            state_nxt = S_CDIV;
        end
      end
      S_CSUM: begin
        if (sts.out_free) begin
          cmd.load_sum  = 1'b1;
          cmd.clr_point = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== sv/stream_moment_reducer.sv =====
// Top level: weighted mean and dispersion reducer over per-point stream records.
// A record goes from acceptance to the next acceptance through capture, decode, ten passes
// through the one shared multiplier (only the density pass past the stream limit) and one
// accumulate step, then the echo load when enabled. Closing a point runs one division per entry on
// the serial divider (one quotient bit per cycle): the three means, then the six dispersion entries.
// Output stalls extend both. Reset clears the accumulators, the result valid flag, the config.
module stream_moment_reducer #(
  parameter int MAX_STREAMS = smr_pkg::MAX_STREAMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [smr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [smr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  smr_in_if.sink                         in_ch,
  smr_out_if.source                      out_ch
);
  import smr_pkg::*;

  smr_cmd_t cmd;
  smr_sts_t sts;
  logic     in_rdy;

  assign in_ch.ready = in_rdy;

  smr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  smr_dp #(.MAX_STREAMS(MAX_STREAMS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Never overwrite a result that has not been taken
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_echo || cmd.load_sum) |-> sts.out_free)
    else $error("result register loaded while occupied");

  // No transaction accepted while a division runs
  a_no_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_rdy) |-> !sts.div_busy)
    else $error("transaction accepted during division");

  // Zero weight sum gives a zero mean and dispersion (checked on mean_vx and disp_xy)
  a_zero_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_sum && sts.w_zero) |=> (out_ch.mean_vx == '0 && out_ch.disp_xy == '0))
    else $error("nonzero summary for zero weight sum");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the moment reducer: directed and random points checked against a local predictor.
module tb_top;
  import smr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [31:0] density;
    logic [23:0] mvx, mvy, mvz;
    logic [46:0] dxx, dyy, dzz;
    logic [47:0] dxy, dxz, dyz;
    logic [7:0]  cnt;
  } moment_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  smr_in_if  in_ch();
  smr_out_if out_ch();

  stream_moment_reducer uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #1 clk = ~clk;

  // predictor copy of configuration and point state
  logic        geo_sel;
  logic        echo_on;
  logic [23:0] inv_rho;
  longint      w_sum;
  longint      fm[3];
  longint      sm[6];
  int          seen;

  moment_res_t expected_q[$];
  int  errors = 0;
  bit  calm = 1'b0;
  int  idle_cycles = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.density_geometric = '0;
    in_ch.density_interpolated = '0;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    in_ch.no_stream = 1'b0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic longint fl12(longint x);
    longint q;
    q = x / 4096;
    if (x < 0 && (x % 4096) != 0) q -= 1;
    return q;
  endfunction

  function automatic longint clampv(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic logic [31:0] scaled_density(longint d);
    longint p;
    p = (d * longint'(inv_rho)) >>> 12;
    return p > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  function automatic int ia(int j);
    return j < 3 ? 0 : (j < 5 ? 1 : 2);
  endfunction

  function automatic int ib(int j);
    return j == 0 ? 0 : ((j == 1 || j == 3) ? 1 : 2);
  endfunction

  // work out the results of one input transaction
  task automatic predict_moments(logic [23:0] dg, logic [23:0] di, logic [23:0] vx,
                                 logic [23:0] vy, logic [23:0] vz, logic ns, logic lst);
    longint w, v[3], wv[3], mean[3], disp[6], q, r, e, s;
    moment_res_t o;
    if (!ns) begin
      w = geo_sel ? longint'(dg) : longint'(di);
      v[0] = longint'(signed'(vx));
      v[1] = longint'(signed'(vy));
      v[2] = longint'(signed'(vz));
      if (seen < 255) begin
        w_sum += w;
        for (int i = 0; i < 3; i++) begin
          wv[i] = fl12(w * v[i]);
          fm[i] += wv[i];
        end
        for (int j = 0; j < 6; j++) sm[j] += fl12(wv[ia(j)] * v[ib(j)]);
        seen++;
      end
      if (echo_on) begin
        o = '{default: '0};
        o.kind = 1'b0;
        o.density = scaled_density(w);
        o.mvx = vx; o.mvy = vy; o.mvz = vz;
        expected_q = {expected_q, o};
      end
    end
    if (lst) begin
      mean = '{0, 0, 0};
      disp = '{0, 0, 0, 0, 0, 0};
      if (w_sum > 0) begin
        for (int i = 0; i < 3; i++)
          mean[i] = clampv((fm[i] * 4096) / w_sum, -8388608, 8388607);
        if (seen >= 2) begin
          for (int j = 0; j < 6; j++) begin
            q = sm[j] / w_sum;
            r = sm[j] % w_sum;
            e = q * 4096 + (r * 4096) / w_sum;
            s = e - fl12(mean[ia(j)] * mean[ib(j)]);
            if (ia(j) == ib(j)) s = clampv(s, 0, 64'h7FFF_FFFF_FFFF);
            else s = clampv(s, -64'sh8000_0000_0000, 64'h7FFF_FFFF_FFFF);
            disp[j] = s;
          end
        end
      end
      o.kind = 1'b1;
      o.density = scaled_density(w_sum);
      o.mvx = mean[0][23:0]; o.mvy = mean[1][23:0]; o.mvz = mean[2][23:0];
      o.dxx = disp[0][46:0]; o.dxy = disp[1][47:0]; o.dxz = disp[2][47:0];
      o.dyy = disp[3][46:0]; o.dyz = disp[4][47:0]; o.dzz = disp[5][46:0];
      o.cnt = seen[7:0];
      expected_q = {expected_q, o};
      w_sum = 0; fm = '{0, 0, 0}; sm = '{0, 0, 0, 0, 0, 0}; seen = 0;
    end
  endtask

  // send one transaction, with random idle cycles ahead of it unless calm is set
  task automatic send_record(logic [23:0] dg, logic [23:0] di, logic [23:0] vx,
                             logic [23:0] vy, logic [23:0] vz, logic ns, logic lst);
    while (!calm && $urandom_range(99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.density_geometric <= dg;
    in_ch.density_interpolated <= di;
    in_ch.vel_x <= vx;
    in_ch.vel_y <= vy;
    in_ch.vel_z <= vz;
    in_ch.no_stream <= ns;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_moments(dg, di, vx, vy, vz, ns, lst);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until all results are back, then let the close pass finish
  task automatic drain_results();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_USE_GEO:    geo_sel = val[0];
      CFG_PER_STREAM: echo_on = val[0];
      CFG_INV_RHO:    inv_rho = val;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_field();
    case ($urandom_range(5))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'h800000;
      3: return 24'h7FFFFF;
      4: return 24'($urandom_range(32767) - 16384);
      default: return 24'($urandom());
    endcase
  endfunction

  task automatic test_directed();
    send_record(24'hFFFFFF, 24'h001000, 24'h7FFFFF, 24'h800000, 24'h000000, 1'b0, 1'b1);
    send_record(24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000, 24'hFFFFFF, 1'b0, 1'b0);
    send_record(24'h001000, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'h001000, 1'b0, 1'b1);
    // zero weight sum with two streams when the interpolated density is selected
    send_record(24'h001000, 24'h000000, 24'h001000, 24'h002000, 24'h003000, 1'b0, 1'b0);
    send_record(24'h001000, 24'h000000, 24'hFFF000, 24'h002000, 24'h003000, 1'b0, 1'b1);
    // ignored record, then empty close
    send_record(24'h123456, 24'h654321, 24'h111111, 24'h222222, 24'h333333, 1'b1, 1'b0);
    send_record(24'h123456, 24'h654321, 24'h111111, 24'h222222, 24'h333333, 1'b1, 1'b1);
    // small ordinary point closed by no_stream
    send_record(24'h002000, 24'h001800, 24'h000800, 24'hFFF800, 24'h004000, 1'b0, 1'b0);
    send_record(24'h003000, 24'h000800, 24'hFFE000, 24'h001000, 24'hFFFC00, 1'b0, 1'b0);
    send_record(24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1, 1'b1);
    drain_results();
  endtask

  // more than the stream limit in one point
  task automatic test_stream_limit();
    for (int i = 0; i < 258; i++)
      send_record(24'($urandom()), 24'($urandom_range(8192)),
                  24'($urandom_range(16383) - 8192), rand_field(), 24'($urandom()),
                  1'b0, i == 257);
    drain_results();
  endtask

  task automatic test_random(int n_items);
    int left, len;
    left = n_items;
    while (left > 0) begin
      len = $urandom_range(6);
      for (int i = 0; i <= len; i++) begin
        send_record(rand_field(), rand_field(), rand_field(), rand_field(), rand_field(),
                    $urandom_range(9) == 0, i == len);
        left--;
      end
    end
    drain_results();
  endtask

  // receive side: random stall unless calm is set, and field by field compare
  always @(posedge clk) begin
    moment_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual kind %0b density %0h",
                 $realtime, out_ch.kind, out_ch.density);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_ch.kind !== exp_r.kind || out_ch.density !== exp_r.density ||
            out_ch.mean_vx !== exp_r.mvx || out_ch.mean_vy !== exp_r.mvy ||
            out_ch.mean_vz !== exp_r.mvz || out_ch.disp_xx !== exp_r.dxx ||
            out_ch.disp_xy !== exp_r.dxy || out_ch.disp_xz !== exp_r.dxz ||
            out_ch.disp_yy !== exp_r.dyy || out_ch.disp_yz !== exp_r.dyz ||
            out_ch.disp_zz !== exp_r.dzz || out_ch.stream_count !== exp_r.cnt) begin
          errors++;
          $display("%0t: mismatch expected k%0b d%0h m %0h %0h %0h x %0h %0h %0h %0h %0h %0h c%0d",
                   $realtime, exp_r.kind, exp_r.density, exp_r.mvx, exp_r.mvy, exp_r.mvz,
                   exp_r.dxx, exp_r.dxy, exp_r.dxz, exp_r.dyy, exp_r.dyz, exp_r.dzz,
                   exp_r.cnt);
          $display("%0t: mismatch actual   k%0b d%0h m %0h %0h %0h x %0h %0h %0h %0h %0h %0h c%0d",
                   $realtime, out_ch.kind, out_ch.density, out_ch.mean_vx, out_ch.mean_vy,
                   out_ch.mean_vz, out_ch.disp_xx, out_ch.disp_xy, out_ch.disp_xz,
                   out_ch.disp_yy, out_ch.disp_yz, out_ch.disp_zz, out_ch.stream_count);
        end
      end
    end
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 29);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAIL stream_moment_reducer");
      $finish;
    end
  end

  initial begin
    geo_sel = 1'b0; echo_on = 1'b0; inv_rho = 24'd4096;
    w_sum = 0; fm = '{0, 0, 0}; sm = '{0, 0, 0, 0, 0, 0}; seen = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_reg(CFG_PER_STREAM, 24'd1);
    write_reg(CFG_USE_GEO, 24'd1);
    write_reg(CFG_INV_RHO, 24'hFFFFFF);
    test_directed();
    test_stream_limit();
    write_reg(CFG_INV_RHO, 24'd0);
    test_random(300);
    write_reg(CFG_USE_GEO, 24'd0);
    write_reg(CFG_INV_RHO, 24'h000800);
    calm = 1'b1;
    test_random(400);
    calm = 1'b0;
    write_reg(CFG_PER_STREAM, 24'd0);
    write_reg(CFG_INV_RHO, 24'($urandom()));
    test_random(500);
    write_reg(CFG_PER_STREAM, 24'd1);
    write_reg(CFG_USE_GEO, 24'd1);
    write_reg(CFG_INV_RHO, 24'd4096);
    test_random(400);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS stream_moment_reducer");
    end else begin
      $display("FAIL stream_moment_reducer");
    end
    $finish;
  end
endmodule
